FILE: hw/rtl/llcre_pkg.sv
`default_nettype none

package llcre_pkg;

    // Grid geometry
    localparam int GRID_SIZE = 64;
    localparam int COORD_W   = 6;
    localparam int CNT_W     = 4;

    // Rule register widths
    localparam int MASK_W    = 9;
    localparam int CFG_IDX_W = 2;

    // Command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BIRTH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_SURVIVE = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MODE    = 2'd2;

    // Neighbourhood codes
    localparam logic MODE_MOORE = 1'b0;
    localparam logic MODE_VN    = 1'b1;

    // Reset values of the rule registers
    localparam logic [MASK_W-1:0] BIRTH_RST   = 9'd8;
    localparam logic [MASK_W-1:0] SURVIVE_RST = 9'd12;

    typedef logic [GRID_SIZE-1:0] t_row;

    typedef struct packed {
        logic [MASK_W-1:0] birth;
        logic [MASK_W-1:0] survive;
        logic              mode;
    } t_rule_cfg;

    // Step one coordinate back with wraparound
    function automatic logic [COORD_W-1:0] wrap_dec(input logic [COORD_W-1:0] x);
        logic [COORD_W-1:0] res;
        if (x == '0) begin
            res = COORD_W'(GRID_SIZE - 1);
        end else begin
            res = x - COORD_W'(1);
        end
        return res;
    endfunction

    // Step one coordinate forward with wraparound
    function automatic logic [COORD_W-1:0] wrap_inc(input logic [COORD_W-1:0] x);
        logic [COORD_W-1:0] res;
        if (x == COORD_W'(GRID_SIZE - 1)) begin
            res = '0;
        end else begin
            res = x + COORD_W'(1);
        end
        return res;
    endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/llcre_rule.sv
`default_nettype none

module llcre_rule (
    input  llcre_pkg::t_row                    i_up_row,
    input  llcre_pkg::t_row                    i_mid_row,
    input  llcre_pkg::t_row                    i_dn_row,
    input  logic [llcre_pkg::COORD_W-1:0]      i_col,
    input  llcre_pkg::t_rule_cfg               i_cfg,
    output logic                               o_cur,
    output logic                               o_nxt
);
    import llcre_pkg::*;

    logic [COORD_W-1:0] col_l;
    logic [COORD_W-1:0] col_r;
    logic [CNT_W-1:0]   cnt_vn;
    logic [CNT_W-1:0]   cnt_diag;
    logic [CNT_W-1:0]   cnt;

    // Wrap the neighbour columns
    assign col_l = wrap_dec(i_col);
    assign col_r = wrap_inc(i_col);

    // Count the edge neighbours, then the corner neighbours
    assign cnt_vn = CNT_W'(i_up_row[i_col]) + CNT_W'(i_dn_row[i_col])
                  + CNT_W'(i_mid_row[col_l]) + CNT_W'(i_mid_row[col_r]);
    assign cnt_diag = CNT_W'(i_up_row[col_l]) + CNT_W'(i_up_row[col_r])
                    + CNT_W'(i_dn_row[col_l]) + CNT_W'(i_dn_row[col_r]);
    assign cnt = (i_cfg.mode == MODE_VN) ? cnt_vn : cnt_vn + cnt_diag;

    // Look up the rule for the current state
    assign o_cur = i_mid_row[i_col];
    assign o_nxt = o_cur ? i_cfg.survive[cnt] : i_cfg.birth[cnt];

endmodule

`default_nettype wire

FILE: hw/rtl/life_like_cell_rule_engine.sv
`default_nettype none

// Life-like cell rule engine on a 64 x 64 toroidal grid of one-bit cells.
// Input channel (i_in_valid / o_in_stall) carries one command per transfer:
// a write stores i_value into cell (i_row, i_col); an evaluate applies the
// birth/survive rule to that cell and sends a transfer on the output channel
// (o_out_valid / i_out_stall) only when the cell would change state.
// Evaluation never modifies the grid; the caller writes updates back.
// The grid is held as 64 rows of 64 bits in a synchronous memory with one
// read port; an evaluate reads the row above, its own row and the row below,
// one read per cycle, and the next command is taken in the cycle its result
// is decided. A write is a row read-modify-write. The result is registered
// in the output register once the last row read has returned. The rule
// registers are written through the cfg channel (always ready); the user
// must write them only while the block is idle, which it does not enforce.
// Reset clears the per-row valid flags, so every cell reads dead at once;
// no clearing pass is needed. Rule registers return to birth 8, survive 12,
// Moore neighbourhood. When the receiver stalls, a finished result waits in
// the output register; a second change found meanwhile holds the engine and
// stalls the input until the output register frees.

module life_like_cell_rule_engine (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    // Command channel
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  logic                                i_cmd,
    input  logic [llcre_pkg::COORD_W-1:0]       i_row,
    input  logic [llcre_pkg::COORD_W-1:0]       i_col,
    input  logic                                i_value,
    // Result channel
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output logic [llcre_pkg::COORD_W-1:0]       o_out_row,
    output logic [llcre_pkg::COORD_W-1:0]       o_out_col,
    output logic                                o_new_state,
    // Configuration channel
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [llcre_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [llcre_pkg::MASK_W-1:0]        i_cfg_data
);
    import llcre_pkg::*;

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_RD_MID = 3'd1;
    localparam logic [2:0] S_RD_DN  = 3'd2;
    localparam logic [2:0] S_EVAL   = 3'd3;
    localparam logic [2:0] S_WBACK  = 3'd4;

    // Grid storage
    t_row                 r_mem [GRID_SIZE];
    logic [GRID_SIZE-1:0] r_row_vld;
    t_row                 r_rd_data;
    logic                 r_rd_vld;

    // Control and item registers
    logic [2:0]           r_state, n_state;
    logic                 r_cmd;
    logic [COORD_W-1:0]   r_row;
    logic [COORD_W-1:0]   r_col;
    logic                 r_value;
    t_row                 r_up_row;
    t_row                 r_mid_row;
    t_rule_cfg            r_cfg;

    // Output register
    logic                 r_out_valid;
    logic [COORD_W-1:0]   r_out_row;
    logic [COORD_W-1:0]   r_out_col;
    logic                 r_new_state;

    logic                 rd_en;
    logic [COORD_W-1:0]   rd_addr;
    t_row                 rd_row;
    logic                 wr_en;
    t_row                 wr_data;
    logic                 in_take;
    logic                 in_ok;
    logic                 cur;
    logic                 nxt;
    logic                 change;
    logic                 out_free;
    logic                 eval_done;
    logic                 out_load;

    // An unwritten row reads as all dead
    assign rd_row = r_rd_vld ? r_rd_data : '0;

    llcre_rule u_rule (
        .i_up_row  (r_up_row),
        .i_mid_row (r_mid_row),
        .i_dn_row  (rd_row),
        .i_col     (r_col),
        .i_cfg     (r_cfg),
        .o_cur     (cur),
        .o_nxt     (nxt)
    );

    assign change    = (nxt != cur);
    assign out_free  = !r_out_valid || !i_out_stall;
    assign eval_done = !change || out_free;
    assign out_load  = (r_state == S_EVAL) && change && out_free;

    assign o_in_stall = !((r_state == S_IDLE) || ((r_state == S_EVAL) && eval_done));
    assign in_take    = i_in_valid && !o_in_stall;
    assign in_ok      = ({1'b0, i_row} < (COORD_W+1)'(GRID_SIZE))
                     && ({1'b0, i_col} < (COORD_W+1)'(GRID_SIZE));

    // Sequence the row reads and the write-back
    always_comb begin
        n_state = r_state;
        rd_en   = 1'b0;
        rd_addr = r_row;
        wr_en   = 1'b0;
        wr_data = rd_row;
        unique case (r_state)
            S_IDLE, S_EVAL: begin
                if (r_state == S_IDLE || eval_done) begin
                    n_state = S_IDLE;
                    if (in_take && in_ok) begin
                        rd_en = 1'b1;
                        if (i_cmd == CMD_EVAL) begin
                            rd_addr = wrap_dec(i_row);
                            n_state = S_RD_MID;
                        end else begin
                            rd_addr = i_row;
                            n_state = S_WBACK;
                        end
                    end
                end
            end
            S_RD_MID: begin
                rd_en   = 1'b1;
                rd_addr = r_row;
                n_state = S_RD_DN;
            end
            S_RD_DN: begin
                rd_en   = 1'b1;
                rd_addr = wrap_inc(r_row);
                n_state = S_EVAL;
            end
            S_WBACK: begin
                wr_en          = 1'b1;
                wr_data[r_col] = r_value;
                n_state        = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Memory read and write ports
    always_ff @(posedge i_clk) begin
        if (rd_en) begin
            r_rd_data <= r_mem[rd_addr];
            r_rd_vld  <= r_row_vld[rd_addr];
        end
        if (wr_en) begin
            r_mem[r_row] <= wr_data;
        end
    end

    // Track which rows hold written data
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_vld <= '0;
        end else if (wr_en) begin
            r_row_vld[r_row] <= 1'b1;
        end
    end

    // Advance the state machine
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Capture the command and the rows read so far
    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_cmd   <= i_cmd;
            r_row   <= i_row;
            r_col   <= i_col;
            r_value <= i_value;
        end
        if (r_state == S_RD_MID) begin
            r_up_row <= rd_row;
        end
        if (r_state == S_RD_DN && r_cmd == CMD_EVAL) begin
            r_mid_row <= rd_row;
        end
    end

    // Hold the result until the receiver takes it
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_row   <= r_row;
            r_out_col   <= r_col;
            r_new_state <= nxt;
        end
    end

    // Rule register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.birth   <= BIRTH_RST;
            r_cfg.survive <= SURVIVE_RST;
            r_cfg.mode    <= MODE_MOORE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_BIRTH:   r_cfg.birth   <= i_cfg_data;
                CFG_SURVIVE: r_cfg.survive <= i_cfg_data;
                CFG_MODE:    r_cfg.mode    <= i_cfg_data[0];
                default:     ;
            endcase
        end
    end

    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_row   = r_out_row;
    assign o_out_col   = r_out_col;
    assign o_new_state = r_new_state;

endmodule

`default_nettype wire

FILE: sim/cell_rule_checker.sv
`timescale 1ns / 100ps

module cell_rule_checker (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // Command channel
    input  logic                            i_in_valid,
    input  logic                            i_in_stall,
    input  logic                            i_cmd,
    input  logic [llcre_pkg::COORD_W-1:0]   i_row,
    input  logic [llcre_pkg::COORD_W-1:0]   i_col,
    input  logic                            i_value,
    // Result channel
    input  logic                            i_out_valid,
    input  logic                            i_out_stall,
    input  logic [llcre_pkg::COORD_W-1:0]   i_out_row,
    input  logic [llcre_pkg::COORD_W-1:0]   i_out_col,
    input  logic                            i_new_state,
    // Configuration channel
    input  logic                            i_cfg_valid,
    input  logic                            i_cfg_ready,
    input  logic [llcre_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [llcre_pkg::MASK_W-1:0]    i_cfg_data,
    // Status toward the testbench top
    output int                              o_fail_count,
    output int                              o_pending
);

    import llcre_pkg::*;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        logic               state;
    } t_cell_change;

    // Shadow copy of the grid and the rule registers
    bit           cells [GRID_SIZE][GRID_SIZE];
    t_rule_cfg    rule;
    t_cell_change pending_changes [$];
    int           mismatches = 0;

    // Live neighbours of one cell on the torus
    function automatic int live_neighbours(input int r, input int c);
        int up;
        int dn;
        int lf;
        int rt;
        int n;
        up = (r + GRID_SIZE - 1) % GRID_SIZE;
        dn = (r + 1) % GRID_SIZE;
        lf = (c + GRID_SIZE - 1) % GRID_SIZE;
        rt = (c + 1) % GRID_SIZE;
        n = int'(cells[up][c]) + int'(cells[dn][c]) + int'(cells[r][lf]) + int'(cells[r][rt]);
        if (rule.mode == MODE_MOORE) begin
            n = n + int'(cells[up][lf]) + int'(cells[up][rt])
                  + int'(cells[dn][lf]) + int'(cells[dn][rt]);
        end
        return n;
    endfunction

    always @(posedge i_clk) begin
        t_cell_change got;
        t_cell_change want;
        t_cell_change pred;
        int           cnt;
        bit           cur;
        bit           nxt;

        if (!i_rst_n) begin
            // Clear the shadow state along with the block
            foreach (cells[r, c]) cells[r][c] = 1'b0;
            rule.birth   = BIRTH_RST;
            rule.survive = SURVIVE_RST;
            rule.mode    = MODE_MOORE;
            pending_changes.delete();
        end else begin
            // Track rule register writes; indexes past the rule registers are dropped
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_index)
                    CFG_BIRTH: begin
                        rule.birth = i_cfg_data;
                    end
                    CFG_SURVIVE: begin
                        rule.survive = i_cfg_data;
                    end
                    CFG_MODE: begin
                        rule.mode = i_cfg_data[0];
                    end
                    default: begin
                    end
                endcase
            end

            // Apply a write, or predict the outcome of an evaluate
            if (i_in_valid && !i_in_stall) begin
                if (i_cmd == CMD_WRITE) begin
                    cells[i_row][i_col] = i_value;
                end else begin
                    cur = cells[i_row][i_col];
                    cnt = live_neighbours(int'(i_row), int'(i_col));
                    nxt = cur ? rule.survive[cnt] : rule.birth[cnt];
                    if (nxt != cur) begin
                        pred = '{row: i_row, col: i_col, state: nxt};
                        pending_changes.insert(pending_changes.size(), pred);
                    end
                end
            end

            // Compare each result transfer with the oldest predicted change
            if (i_out_valid && !i_out_stall) begin
                got = '{row: i_out_row, col: i_out_col, state: i_new_state};
                if (pending_changes.size() == 0) begin
                    $error("unexpected result: out_row %0d out_col %0d new_state %0d",
                           got.row, got.col, got.state);
                    mismatches++;
                end else begin
                    want = pending_changes.pop_front();
                    if (got.row !== want.row) begin
                        $error("out_row: expected %0d, actual %0d", want.row, got.row);
                        mismatches++;
                    end
                    if (got.col !== want.col) begin
                        $error("out_col: expected %0d, actual %0d", want.col, got.col);
                        mismatches++;
                    end
                    if (got.state !== want.state) begin
                        $error("new_state: expected %0d, actual %0d", want.state, got.state);
                        mismatches++;
                    end
                end
            end
        end

        o_pending    <= pending_changes.size();
        o_fail_count <= mismatches;
    end

endmodule

FILE: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

    import llcre_pkg::*;

    localparam int RESET_CYC      = 8;
    localparam int SETTLE_CYC     = 10;
    localparam int HOLD_CYC       = 60;
    localparam int PHASE_ITEMS    = 210;
    localparam int PHASES         = 6;
    localparam int WATCHDOG_LIMIT = 1000;

    // Register index past the rule registers
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    logic                 in_cmd    = CMD_WRITE;
    logic [COORD_W-1:0]   in_row    = '0;
    logic [COORD_W-1:0]   in_col    = '0;
    logic                 in_value  = 1'b0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    logic [COORD_W-1:0]   out_row;
    logic [COORD_W-1:0]   out_col;
    logic                 new_state;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = CFG_BIRTH;
    logic [MASK_W-1:0]    cfg_data  = '0;

    int fail_count;
    int pending;
    int gap_pct   = 0;
    int stall_pct = 0;
    bit hold_req  = 1'b0;
    bit hold_done = 1'b0;
    int quiet_cycles = 0;

    // Rule settings per random phase; phases 3 and 5 draw theirs at random
    logic [MASK_W-1:0] birth_tab   [PHASES] = '{9'h1FF, 9'h000, 9'h008, 9'h000, 9'h0AA, 9'h000};
    logic [MASK_W-1:0] survive_tab [PHASES] = '{9'h000, 9'h1FF, 9'h00C, 9'h000, 9'h155, 9'h000};
    logic              mode_tab    [PHASES] = '{MODE_MOORE, MODE_VN, MODE_VN,
                                                MODE_MOORE, MODE_MOORE, MODE_VN};
    int                gap_tab     [PHASES] = '{20, 30, 10, 40, 25, 0};
    int                stall_tab   [PHASES] = '{25, 10, 40, 20, 30, 0};

    life_like_cell_rule_engine DUT (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .o_in_stall  (in_stall),
        .i_cmd       (in_cmd),
        .i_row       (in_row),
        .i_col       (in_col),
        .i_value     (in_value),
        .o_out_valid (out_valid),
        .i_out_stall (out_stall),
        .o_out_row   (out_row),
        .o_out_col   (out_col),
        .o_new_state (new_state),
        .i_cfg_valid (cfg_valid),
        .o_cfg_ready (cfg_ready),
        .i_cfg_index (cfg_index),
        .i_cfg_data  (cfg_data)
    );

    cell_rule_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_in_valid   (in_valid),
        .i_in_stall   (in_stall),
        .i_cmd        (in_cmd),
        .i_row        (in_row),
        .i_col        (in_col),
        .i_value      (in_value),
        .i_out_valid  (out_valid),
        .i_out_stall  (out_stall),
        .i_out_row    (out_row),
        .i_out_col    (out_col),
        .i_new_state  (new_state),
        .i_cfg_valid  (cfg_valid),
        .i_cfg_ready  (cfg_ready),
        .i_cfg_index  (cfg_index),
        .i_cfg_data   (cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        forever #1 clk = ~clk;
    end

    // Offer one command and hold it until the transfer completes
    task automatic send_cmd(input logic cmd, input logic [COORD_W-1:0] row,
                            input logic [COORD_W-1:0] col, input logic value);
        if ($urandom_range(0, 99) < gap_pct) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_cmd   <= cmd;
        in_row   <= row;
        in_col   <= col;
        in_value <= value;
        do @(posedge clk); while (in_stall);
    endtask

    // Write one rule register through the config channel
    task automatic write_rule(input logic [CFG_IDX_W-1:0] idx, input logic [MASK_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // Drop valid, wait for every predicted change, then let a silent evaluate finish
    task automatic settle_engine();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0) @(posedge clk);
        repeat (SETTLE_CYC) @(posedge clk);
    endtask

    // Random command clustered in a small window so neighbours are often alive
    task automatic random_cmd(input int base_r, input int base_c);
        logic               cmd;
        logic               value;
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
        cmd   = 1'($urandom_range(0, 1));
        value = 1'($urandom_range(0, 1));
        if ($urandom_range(0, 4) == 0) begin
            row = COORD_W'($urandom_range(0, GRID_SIZE - 1));
            col = COORD_W'($urandom_range(0, GRID_SIZE - 1));
        end else begin
            row = COORD_W'((base_r + int'($urandom_range(0, 6))) % GRID_SIZE);
            col = COORD_W'((base_c + int'($urandom_range(0, 6))) % GRID_SIZE);
        end
        send_cmd(cmd, row, col, value);
    endtask

    // Receiver: random stall bursts, plus one long hold on request
    initial begin
        forever begin
            @(posedge clk);
            if (hold_req && !hold_done) begin
                hold_done = 1'b1;
                out_stall <= 1'b1;
                repeat (HOLD_CYC) @(posedge clk);
                out_stall <= 1'b0;
            end else if ($urandom_range(0, 99) < stall_pct) begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 3)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    // Watchdog: end the run if no channel moves for too long
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout: no transfer for %0d cycles", WATCHDOG_LIMIT);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int               base_r;
        int               base_c;
        logic [MASK_W-1:0] birth;
        logic [MASK_W-1:0] survive;
        logic              mode;

        repeat (RESET_CYC) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part under the reset rule (B3/S23, Moore), corners and wraparound
        gap_pct   = 15;
        stall_pct = 15;
        send_cmd(CMD_WRITE, 6'd0,  6'd0,  1'b1);
        send_cmd(CMD_WRITE, 6'd0,  6'd63, 1'b1);
        send_cmd(CMD_WRITE, 6'd63, 6'd0,  1'b1);
        send_cmd(CMD_EVAL,  6'd63, 6'd63, 1'b1);
        send_cmd(CMD_EVAL,  6'd0,  6'd0,  1'b0);
        send_cmd(CMD_WRITE, 6'd0,  6'd0,  1'b0);
        send_cmd(CMD_EVAL,  6'd0,  6'd63, 1'b0);
        send_cmd(CMD_EVAL,  6'd32, 6'd32, 1'b0);
        send_cmd(CMD_WRITE, 6'd32, 6'd32, 1'b0);
        send_cmd(CMD_WRITE, 6'd42, 6'd21, 1'b1);
        send_cmd(CMD_WRITE, 6'd21, 6'd42, 1'b1);
        send_cmd(CMD_WRITE, 6'd42, 6'd22, 1'b1);
        send_cmd(CMD_WRITE, 6'd43, 6'd21, 1'b1);
        send_cmd(CMD_EVAL,  6'd43, 6'd22, 1'b1);
        send_cmd(CMD_EVAL,  6'd42, 6'd21, 1'b0);
        send_cmd(CMD_EVAL,  6'd21, 6'd42, 1'b0);
        send_cmd(CMD_EVAL,  6'd63, 6'd0,  1'b0);
        send_cmd(CMD_EVAL,  6'd62, 6'd63, 1'b0);
        settle_engine();

        // Random phases, each under its own rule
        for (int phase = 0; phase < PHASES; phase++) begin
            birth   = birth_tab[phase];
            survive = survive_tab[phase];
            mode    = mode_tab[phase];
            if (phase == 3 || phase == 5) begin
                birth   = MASK_W'($urandom_range(0, 511));
                survive = MASK_W'($urandom_range(0, 511));
                mode    = 1'($urandom_range(0, 1));
            end
            write_rule(CFG_BIRTH, birth);
            write_rule(CFG_SURVIVE, survive);
            write_rule(CFG_MODE, {(MASK_W-1)'($urandom_range(0, 255)), mode});
            if (phase == 1) begin
                // Unused index, must leave the rule untouched
                write_rule(CFG_SPARE, MASK_W'($urandom_range(0, 511)));
            end

            gap_pct   = gap_tab[phase];
            stall_pct = stall_tab[phase];
            base_r    = (phase == 0) ? 60 : int'($urandom_range(0, GRID_SIZE - 1));
            base_c    = (phase == 0) ? 61 : int'($urandom_range(0, GRID_SIZE - 1));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                // Back-pressure the result side long enough to fill the engine
                if (phase == 0 && n == 50) begin
                    hold_req = 1'b1;
                end
                random_cmd(base_r, base_c);
            end
            settle_engine();
        end

        if (fail_count == 0 && pending == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
